// ===== rtl/core/was_pkg.sv =====
// Shared types, constants and helpers for the window alignment score block.
package was_pkg;

	// Grid scores: steps of magnitude up to 16 (5-bit signed costs), with margin.
	localparam int SCORE_W = 12;
	// Bases carried by each input field.
	localparam int N_BASES = 10;

	typedef logic signed [SCORE_W-1:0] score_t;

	localparam score_t SAT_HI = 255;
	localparam score_t SAT_LO = -256;

	typedef enum logic [1:0] {
		OP_INS   = 2'd0,
		OP_DEL   = 2'd1,
		OP_MATCH = 2'd2,
		OP_MIS   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_INSERT   = 2'd0,
		CFG_DELETE   = 2'd1,
		CFG_MISMATCH = 2'd2,
		CFG_MATCH    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [4:0] ins;
		logic signed [4:0] del;
		logic signed [4:0] mis;
		logic signed [4:0] mat;
	} score_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROW,
		ST_FILL,
		ST_TB_RD,
		ST_TB_OP,
		ST_DONE
	} state_t;

	function automatic score_t sext5(logic signed [4:0] c);
		return score_t'(c);
	endfunction

	// Base k of a packed field; bases past the field read as A.
	function automatic logic [1:0] base_at(logic [2*N_BASES-1:0] bits, int k);
		logic [1:0] b;
		b = 2'd0;
		if (k < N_BASES) begin
			b = bits[2*k +: 2];
		end
		return b;
	endfunction

	function automatic logic [8:0] sat9(score_t v);
		logic [8:0] r;
		if (v > SAT_HI) begin
			r = 9'h0FF;
		end else if (v < SAT_LO) begin
			r = 9'h100;
		end else begin
			r = v[8:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/was_cell.sv =====
// Shared cell unit: insertion, deletion and diagonal candidates, strict-greater pick.
module was_cell import was_pkg::*; (
	input  score_t     left,
	input  score_t     up,
	input  score_t     diag,
	input  logic       same,
	input  score_cfg_t cfg,
	output score_t     v,
	output op_t        op
);

	score_t v_ins;
	score_t v_del;
	score_t v_dia;
	score_t v_mid;
	op_t    op_mid;

	always_comb begin
		v_ins = left + sext5(cfg.ins);
		v_del = up + sext5(cfg.del);
		v_dia = diag + (same ? sext5(cfg.mat) : sext5(cfg.mis));
		// deletion only if strictly better, then diagonal likewise
		if (v_del > v_ins) begin
			v_mid  = v_del;
			op_mid = OP_DEL;
		end else begin
			v_mid  = v_ins;
			op_mid = OP_INS;
		end
		if (v_dia > v_mid) begin
			v  = v_dia;
			op = same ? OP_MATCH : OP_MIS;
		end else begin
			v  = v_mid;
			op = op_mid;
		end
	end

endmodule

// ===== rtl/core/window_alignment_score.sv =====
// Top level: global alignment score grid with traceback of the leading step.
//
//  channel   dir  signals                         content
//  s_axis    in   s_tvalid s_tready s_tdata[47:0] orig_bases, read_bases, read_len
//  m_axis    out  m_tvalid m_tready m_tdata[31:0] best_score, end_column, advance,
//                                                 lead_score
//  cfg       in   cfg_we cfg_index cfg_data       insert/delete/mismatch/match score
//
// Per item: row 0 is loaded, then the grid is filled one cell a cycle through the
// single cell unit, with a row-start state before each row, then the traceback
// walks back to the origin (one step-memory read and one step each inner cell).
// Each row holds L cells, L being the clamped read length.
// Reset (arst_n low) clears the sequencer, the output valid and the score
// registers to their defaults. s_tready is high only while idle; a finished
// result waits in the output register, and a new item may be taken meanwhile.
module window_alignment_score import was_pkg::*; #(
	parameter int WINDOW_ORIG = 10,
	parameter int WINDOW_READ = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [19:0] orig_bases, [39:20] read_bases, [43:40] read_len, [47:44] zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [8:0] best_score, [12:9] end_column, [17:13] advance, [26:18] lead_score,
	// [31:27] zero
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int IW = $clog2(WINDOW_ORIG + 1);   // row counter
	localparam int JW = $clog2(WINDOW_READ + 1);   // column counter
	localparam int OW = $clog2(WINDOW_ORIG);       // step memory row address
	localparam int RW = $clog2(WINDOW_READ);       // step memory column address
	localparam int LW = (JW > 4) ? JW : 4;
	localparam int AW = (JW + 1 > 5) ? JW + 1 : 5;
	localparam int EW = (JW > 4) ? JW : 4;
	localparam int OP_DEPTH = 1 << (OW + RW);

	state_t     state_q, state_d;
	score_cfg_t cfg_q;

	// item registers
	logic [19:0]   orig_q;
	logic [19:0]   read_q;
	logic [JW-1:0] lr_q;
	logic [LW-1:0] rl_in;
	logic [LW-1:0] rl_clamp;

	// fill datapath
	logic [IW-1:0] i_q;
	logic [JW-1:0] j_q;
	score_t        left_q;
	score_t        diag_q;
	score_t        col0_q;
	score_t        row_rd_q;
	score_t        row_mem [1:WINDOW_READ];
	op_t           op_mem [OP_DEPTH];
	op_t           op_rd_q;

	// best of last row
	score_t        best_q;
	logic [JW-1:0] jmax_q;

	// traceback
	logic [JW-1:0] run_n_q;
	score_t        run_s_q;
	op_t           first_q;
	logic          seen_q;

	logic [OW-1:0] ia;
	logic [RW-1:0] ja;
	logic          same;
	score_t        cell_v;
	op_t           cell_op;
	logic          at_last_row;
	logic          at_last_col;
	logic          tb_origin;
	logic          tb_edge;
	logic          tb_apply;
	op_t           tb_op;
	logic          out_load;
	score_t        first_s;
	score_t        lead;
	logic [AW-1:0] adv_w;
	logic [EW-1:0] end_w;

	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// read length clamped to 1..WINDOW_READ
	always_comb begin
		rl_in = LW'(s_tdata[43:40]);
		if (rl_in == '0) begin
			rl_clamp = LW'(1);
		end else if (rl_in > LW'(WINDOW_READ)) begin
			rl_clamp = LW'(WINDOW_READ);
		end else begin
			rl_clamp = rl_in;
		end
	end

	assign ia   = OW'(i_q - 1'b1);
	assign ja   = RW'(j_q - 1'b1);
	assign same = base_at(orig_q, int'(ia)) == base_at(read_q, int'(ja));

	was_cell u_cell (
		.left (left_q),
		.up   (row_rd_q),
		.diag (diag_q),
		.same (same),
		.cfg  (cfg_q),
		.v    (cell_v),
		.op   (cell_op)
	);

	assign at_last_row = (i_q == IW'(WINDOW_ORIG));
	assign at_last_col = (j_q == lr_q);
	assign tb_origin   = (i_q == '0) && (j_q == '0);
	assign tb_edge     = (i_q == '0) || (j_q == '0);
	// grid edges are fixed: row 0 insertions, column 0 deletions
	assign tb_op       = (state_q == ST_TB_OP) ? op_rd_q :
	                     ((i_q == '0) ? OP_INS : OP_DEL);
	assign tb_apply    = (state_q == ST_TB_OP) ||
	                     ((state_q == ST_TB_RD) && !tb_origin && tb_edge);
	assign out_load    = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (at_last_col) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				state_d = ST_FILL;
			end
			ST_FILL: begin
				if (at_last_col) begin
					state_d = at_last_row ? ST_TB_RD : ST_ROW;
				end
			end
			ST_TB_RD: begin
				if (tb_origin) begin
					state_d = ST_DONE;
				end else if (!tb_edge) begin
					state_d = ST_TB_OP;
				end
			end
			ST_TB_OP: begin
				state_d = ST_TB_RD;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// score registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ins <= -5'sd1;
			cfg_q.del <= -5'sd1;
			cfg_q.mis <= -5'sd1;
			cfg_q.mat <= 5'sd0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INSERT:   cfg_q.ins <= cfg_data;
				CFG_DELETE:   cfg_q.del <= cfg_data;
				CFG_MISMATCH: cfg_q.mis <= cfg_data;
				CFG_MATCH:    cfg_q.mat <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// row buffer: written at the current column, next column read ahead
	always_ff @(posedge clk) begin
		if ((state_q == ST_INIT) && (j_q != '0)) begin
			row_mem[j_q] <= left_q;
		end else if (state_q == ST_FILL) begin
			row_mem[j_q] <= cell_v;
		end
		if (state_q == ST_ROW) begin
			row_rd_q <= row_mem[JW'(1)];
		end else if ((state_q == ST_FILL) && !at_last_col) begin
			row_rd_q <= row_mem[JW'(j_q + 1'b1)];
		end
	end

	// step memory for the inner cells
	always_ff @(posedge clk) begin
		if (state_q == ST_FILL) begin
			op_mem[{ia, ja}] <= cell_op;
		end
		if ((state_q == ST_TB_RD) && !tb_edge) begin
			op_rd_q <= op_mem[{ia, ja}];
		end
	end

	// fill and traceback datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					orig_q <= s_tdata[19:0];
					read_q <= s_tdata[39:20];
					lr_q   <= JW'(rl_clamp);
					left_q <= '0;
					col0_q <= '0;
					j_q    <= '0;
				end
			end
			ST_INIT: begin
				// row 0: j * insert_score
				left_q <= left_q + sext5(cfg_q.ins);
				j_q    <= j_q + 1'b1;
				i_q    <= IW'(1);
			end
			ST_ROW: begin
				diag_q <= col0_q;
				left_q <= col0_q + sext5(cfg_q.del);
				col0_q <= col0_q + sext5(cfg_q.del);
				j_q    <= JW'(1);
				if (at_last_row) begin
					best_q <= col0_q + sext5(cfg_q.del);
					jmax_q <= '0;
				end
			end
			ST_FILL: begin
				left_q <= cell_v;
				diag_q <= row_rd_q;
				// last row: first strict maximum, but the last column wins ties
				if (at_last_row) begin
					if (at_last_col ? (cell_v >= best_q) : (cell_v > best_q)) begin
						best_q <= cell_v;
						jmax_q <= j_q;
					end
				end
				if (!at_last_col) begin
					j_q <= j_q + 1'b1;
				end else if (at_last_row) begin
					j_q     <= (cell_v >= best_q) ? j_q : jmax_q;
					run_n_q <= '0;
					run_s_q <= '0;
					first_q <= OP_INS;
					seen_q  <= 1'b0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			default: begin
			end
		endcase

		// one traceback step; keep the run of insertions nearest the origin
		if (tb_apply) begin
			if (tb_op == OP_INS) begin
				j_q     <= j_q - 1'b1;
				run_n_q <= run_n_q + 1'b1;
				run_s_q <= run_s_q + sext5(cfg_q.ins);
			end else begin
				i_q     <= i_q - 1'b1;
				run_n_q <= '0;
				run_s_q <= '0;
				first_q <= tb_op;
				seen_q  <= 1'b1;
				if (tb_op != OP_DEL) begin
					j_q <= j_q - 1'b1;
				end
			end
		end
	end

	// result fields
	always_comb begin
		first_s = '0;
		if (seen_q) begin
			case (first_q)
				OP_DEL:   first_s = sext5(cfg_q.del);
				OP_MATCH: first_s = sext5(cfg_q.mat);
				OP_MIS:   first_s = sext5(cfg_q.mis);
				default:  first_s = '0;
			endcase
		end
		lead  = run_s_q + first_s;
		adv_w = AW'(run_n_q) - AW'(seen_q && (first_q == OP_DEL));
		end_w = EW'(jmax_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {5'd0, sat9(lead), adv_w[4:0], end_w[3:0], sat9(best_q)};
		end
	end

endmodule
